@@ design/pba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the pixel binning average block.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int OUT_BITS    = 18;
   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_BITS    = 16;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_IMAGE_WIDTH  = 1'b0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1024);

   // per item control from the front to the back
   typedef struct packed {
      logic by_first;
      logic by_last;
      logic row_end;
      logic frame_end;
   } pba_ctl_type;

endpackage
`default_nettype wire

@@ design/pba_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_queue
// Small register queue with full and empty flags; push and pop may coincide.
// ----------------------------------------------------------------------------
module pba_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ design/pba_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_front
// Raster position tracking, block classification and horizontal block sums.
// ----------------------------------------------------------------------------
module pba_front #(
   parameter int BIN_FACTOR = 2,
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16,
   parameter int IDX_BITS   = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pba_pkg::WIDTH_BITS-1:0]   image_width,
   input  logic [pba_pkg::HEIGHT_BITS-1:0]  image_height,
   input  logic                             accept,
   input  logic [PIXEL_BITS-1:0]            pixel_value,
   output logic                             push,
   output logic [pba_pkg::OUT_BITS-1:0]     acc,
   output logic [IDX_BITS-1:0]              xi,
   output pba_pkg::pba_ctl_type             ctl
);
   import pba_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = (CW + 2 > WIDTH_BITS) ? CW + 2 : WIDTH_BITS;
   localparam int HW  = HEIGHT_BITS + 1;
   localparam int BXW = (BIN_FACTOR > 1) ? $clog2(BIN_FACTOR) : 1;

   logic [CW-1:0]          col_ff, col_in;
   logic [CW-1:0]          cb_ff, cb_in;
   logic [IDX_BITS-1:0]    xi_ff, xi_in;
   logic [BXW-1:0]         bx_ff, bx_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [HEIGHT_BITS-1:0] rb_ff, rb_in;
   logic [BXW-1:0]         by_ff, by_in;
   logic [OUT_BITS-1:0]    run_ff, run_in;

   logic [WW-1:0]       wext, weff;
   logic [HW-1:0]       heff;
   logic                col_wrap, row_wrap;
   logic                x_ok, x_end, y_ok, y_end, in_region;
   logic                bx_first, bx_last;
   logic [OUT_BITS-1:0] acc_sum;

   // zero counts as one, width saturates at the line store size
   always_comb begin
      wext = WW'(image_width);
      if (wext == '0) begin
         weff = WW'(1);
      end else if (wext > WW'(MAX_WIDTH)) begin
         weff = WW'(MAX_WIDTH);
      end else begin
         weff = wext;
      end
      heff = (image_height == '0) ? HW'(1) : HW'(image_height);
   end

   assign col_wrap  = (WW'(col_ff) + WW'(1)) >= weff;
   assign row_wrap  = (HW'(row_ff) + HW'(1)) >= heff;
   assign x_ok      = (WW'(cb_ff) + WW'(BIN_FACTOR)) <= weff;
   assign x_end     = (WW'(cb_ff) + WW'(2 * BIN_FACTOR)) > weff;
   assign y_ok      = (HW'(rb_ff) + HW'(BIN_FACTOR)) <= heff;
   assign y_end     = (HW'(rb_ff) + HW'(2 * BIN_FACTOR)) > heff;
   assign in_region = x_ok && y_ok;
   assign bx_first  = (bx_ff == '0);
   assign bx_last   = (bx_ff == BXW'(BIN_FACTOR - 1));
   assign acc_sum   = (bx_first ? '0 : run_ff) + OUT_BITS'(pixel_value);

   assign push          = accept && in_region && bx_last;
   assign acc           = acc_sum;
   assign xi            = xi_ff;
   assign ctl.by_first  = (by_ff == '0);
   assign ctl.by_last   = (by_ff == BXW'(BIN_FACTOR - 1));
   assign ctl.row_end   = x_end;
   assign ctl.frame_end = x_end && y_end;

   always_comb begin
      col_in = col_ff;
      cb_in  = cb_ff;
      xi_in  = xi_ff;
      bx_in  = bx_ff;
      row_in = row_ff;
      rb_in  = rb_ff;
      by_in  = by_ff;
      run_in = run_ff;
      if (accept) begin
         if (in_region) begin
            run_in = acc_sum;
         end
         if (col_wrap) begin
            col_in = '0;
            cb_in  = '0;
            xi_in  = '0;
            bx_in  = '0;
            if (row_wrap) begin
               row_in = '0;
               rb_in  = '0;
               by_in  = '0;
            end else begin
               row_in = row_ff + HEIGHT_BITS'(1);
               if (ctl.by_last) begin
                  by_in = '0;
                  rb_in = rb_ff + HEIGHT_BITS'(BIN_FACTOR);
               end else begin
                  by_in = by_ff + BXW'(1);
               end
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (bx_last) begin
               bx_in = '0;
               cb_in = cb_ff + CW'(BIN_FACTOR);
               xi_in = xi_ff + IDX_BITS'(1);
            end else begin
               bx_in = bx_ff + BXW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         cb_ff  <= '0;
         xi_ff  <= '0;
         bx_ff  <= '0;
         row_ff <= '0;
         rb_ff  <= '0;
         by_ff  <= '0;
         run_ff <= '0;
      end else begin
         col_ff <= col_in;
         cb_ff  <= cb_in;
         xi_ff  <= xi_in;
         bx_ff  <= bx_in;
         row_ff <= row_in;
         rb_ff  <= rb_in;
         by_ff  <= by_in;
         run_ff <= run_in;
      end
   end

endmodule
`default_nettype wire

@@ design/pba_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_back
// Column line store update: read, add block row sum, write back, emit result.
// ----------------------------------------------------------------------------
module pba_back #(
   parameter int DEPTH    = 2048,
   parameter int IDX_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_empty,
   output logic                         in_pop,
   input  logic [pba_pkg::OUT_BITS-1:0] in_acc,
   input  logic [IDX_BITS-1:0]          in_xi,
   input  pba_pkg::pba_ctl_type         in_ctl,
   input  logic                         out_full,
   output logic                         out_push,
   output logic [pba_pkg::OUT_BITS-1:0] out_value,
   output logic                         out_last_in_row,
   output logic                         out_last_in_frame
);
   import pba_pkg::*;

   logic [OUT_BITS-1:0] col_mem [DEPTH];

   logic                s1_vld_ff, s1_vld_in;
   logic [OUT_BITS-1:0] s1_acc_ff;
   logic [IDX_BITS-1:0] s1_xi_ff;
   pba_ctl_type         s1_ctl_ff;
   logic [OUT_BITS-1:0] rdata_ff;
   logic                byp_ff, byp_in;
   logic [OUT_BITS-1:0] byp_val_ff;

   logic                retire, load;
   logic [OUT_BITS-1:0] prior, tot;

   assign retire = s1_vld_ff && (!s1_ctl_ff.by_last || !out_full);
   assign load   = !in_empty && (!s1_vld_ff || retire);
   assign in_pop = load;

   // a write retiring at the edge of the read is forwarded
   assign prior = s1_ctl_ff.by_first ? '0 : (byp_ff ? byp_val_ff : rdata_ff);
   assign tot   = prior + s1_acc_ff;

   assign out_push          = retire && s1_ctl_ff.by_last;
   assign out_value         = tot;
   assign out_last_in_row   = s1_ctl_ff.row_end;
   assign out_last_in_frame = s1_ctl_ff.frame_end;

   assign s1_vld_in = load || (s1_vld_ff && !retire);
   assign byp_in    = load ? (retire && (s1_xi_ff == in_xi)) : byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         byp_ff    <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_acc_ff  <= in_acc;
         s1_xi_ff   <= in_xi;
         s1_ctl_ff  <= in_ctl;
         rdata_ff   <= col_mem[in_xi];
         byp_val_ff <= tot;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         col_mem[s1_xi_ff] <= tot;
      end
   end

endmodule
`default_nettype wire

@@ design/pixel_bin_average.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_bin_average
// Streaming BIN_FACTOR x BIN_FACTOR pixel binning with exact block average.
//
// Pixels enter in raster order on the req_ queue side: an item is taken at a
// clock edge with req_push high and req_full low, one per cycle while req_full
// is low. Results leave on the rsp_ queue side: the oldest result sits on the
// rsp_ ports while rsp_empty is low and is taken at an edge with rsp_pop high.
// binned_value is the block sum, i.e. the average with 2*log2(BIN_FACTOR)
// fraction bits; last_in_row and last_in_frame mark output row and frame end.
// Results pass the middle queue, line store read, add, write back and result
// queue. The line store has one read and one write port and handles one block
// row sum per cycle, so pixels flow at one per cycle while no queue is full.
// When rsp_pop stays low the result queue and the four entry middle queue fill
// and req_full rises; no item is lost. Reset clears the counters and queues
// and sets width and height to 1024; the line store is not cleared and needs
// no clearing pass. csr_we writes image_width (index 0) or image_height
// (index 1); the user must write only while idle; the block does not check.
// ----------------------------------------------------------------------------
module pixel_bin_average #(
   parameter int BIN_FACTOR = 2,
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [PIXEL_BITS-1:0]         req_pixel_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [pba_pkg::OUT_BITS-1:0]  rsp_binned_value,
   output logic                          rsp_last_in_row,
   output logic                          rsp_last_in_frame,
   input  logic                          csr_we,
   input  pba_pkg::csr_index_type        csr_index,
   input  logic [pba_pkg::CSR_BITS-1:0]  csr_wdata
);
   import pba_pkg::*;

   localparam int DEPTH    = MAX_WIDTH / BIN_FACTOR;
   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CTL_BITS = $bits(pba_ctl_type);
   localparam int MID_W    = OUT_BITS + IDX_BITS + CTL_BITS;
   localparam int RSP_W    = OUT_BITS + 2;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;

   logic                front_push;
   logic [OUT_BITS-1:0] front_acc;
   logic [IDX_BITS-1:0] front_xi;
   pba_ctl_type         front_ctl;

   logic                mid_full, mid_empty, mid_pop;
   logic [MID_W-1:0]    mid_in, mid_out;
   logic [OUT_BITS-1:0] mid_acc;
   logic [IDX_BITS-1:0] mid_xi;
   pba_ctl_type         mid_ctl;

   logic                back_push, out_full;
   logic [OUT_BITS-1:0] back_value;
   logic                back_row, back_frame;
   logic [RSP_W-1:0]    rsp_in, rsp_out;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[WIDTH_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_BITS-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_full = mid_full;

   pba_front #(
      .BIN_FACTOR (BIN_FACTOR),
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .accept       (req_push && !req_full),
      .pixel_value  (req_pixel_value),
      .push         (front_push),
      .acc          (front_acc),
      .xi           (front_xi),
      .ctl          (front_ctl)
   );

   assign mid_in = {front_acc, front_xi, front_ctl};

   pba_queue #(
      .WIDTH (MID_W),
      .DEPTH (4)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   assign {mid_acc, mid_xi, mid_ctl} = mid_out;

   pba_back #(
      .DEPTH    (DEPTH),
      .IDX_BITS (IDX_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_empty          (mid_empty),
      .in_pop            (mid_pop),
      .in_acc            (mid_acc),
      .in_xi             (mid_xi),
      .in_ctl            (mid_ctl),
      .out_full          (out_full),
      .out_push          (back_push),
      .out_value         (back_value),
      .out_last_in_row   (back_row),
      .out_last_in_frame (back_frame)
   );

   assign rsp_in = {back_value, back_row, back_frame};

   pba_queue #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (rsp_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty)
   );

   assign {rsp_binned_value, rsp_last_in_row, rsp_last_in_frame} = rsp_out;

   a_front_no_overflow : assert property (@(posedge clock) disable iff (reset)
      front_push |-> !mid_full)
      else $error("front pushed into full middle queue");

   a_back_no_overflow : assert property (@(posedge clock) disable iff (reset)
      back_push |-> !out_full)
      else $error("back pushed into full result queue");

   a_back_needs_item : assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("back popped an empty middle queue");

   a_frame_end_row_end : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_in_frame) |-> rsp_last_in_row)
      else $error("frame end without row end");

endmodule
`default_nettype wire
